/* sv/polygon_normal_newell_assert.svh */
`ifndef POLYGON_NORMAL_NEWELL_ASSERT_SVH
`define POLYGON_NORMAL_NEWELL_ASSERT_SVH

// concurrent check on the rising edge, held off while reset is low
`define PNN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds through reset
`define PNN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pnn_pkg.sv */
`default_nettype none

package pnn_pkg;

  localparam int DEF_MAX_POLY_VERTS = 256;
  localparam int COORD_W = 16;
  localparam int AREA_W = 48;
  localparam int QUEUE_DEPTH = 2;
  localparam int AREA_SHIFT = 44;
  localparam int AREA_SAT_BIT = 92;
  localparam int LIMIT_SHIFT = 30;
  localparam int QUOT_W = 16;

  localparam logic [15:0] THRESHOLD_RESET = 16'd1;
  localparam logic [15:0] NORM_POS_MAX = 16'h7fff;
  localparam logic [15:0] NORM_NEG_MAX = 16'h8000;

  localparam logic [0:0] REG_LENGTH_THRESHOLD = 1'b0;

  // accumulator width: a 34-bit edge term summed over the held vertices plus closing edge
  function automatic int acc_width(input int max_verts);
    return 35 + $clog2(max_verts + 1);
  endfunction

  localparam int DEF_ACC_W = acc_width(DEF_MAX_POLY_VERTS);

  typedef enum logic [1:0] {
    FR_ACCEPT,
    FR_CLOSE_MUL,
    FR_CLOSE_ADD
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_CHECK,
    BK_SQRT,
    BK_DIV_INIT,
    BK_DIV_STEP,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* sv/pnn_front.sv */
`default_nettype none

module pnn_front import pnn_pkg::*; #(
  parameter int MAX_POLY_VERTS = DEF_MAX_POLY_VERTS,
  parameter int ACC_W = DEF_ACC_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic signed [COORD_W-1:0]  vertex_x,
  input  wire logic signed [COORD_W-1:0]  vertex_y,
  input  wire logic signed [COORD_W-1:0]  vertex_z,
  input  wire logic                       last_vertex,
  output logic                            q_push,
  output logic [3*ACC_W-1:0]              q_data,
  input  wire q_stat_t                    q_stat
);

  localparam int CNT_W = $clog2(MAX_POLY_VERTS + 1);
  localparam int DS_W = COORD_W + 1;
  localparam int PROD_W = 2 * DS_W;

  front_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] first_r [3];
  logic signed [COORD_W-1:0] prev_r [3];
  logic signed [COORD_W-1:0] cur [3];
  logic signed [COORD_W-1:0] va [3];
  logic signed [ACC_W-1:0]   acc_r [3];
  logic signed [ACC_W-1:0]   prod_r [3];
  logic signed [ACC_W-1:0]   edge_term [3];
  logic                      in_poly_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      accept;
  logic                      room;

  assign accept = push && !full;
  assign room = cnt_r < CNT_W'(MAX_POLY_VERTS);

  always_comb begin
    cur[0] = vertex_x;
    cur[1] = vertex_y;
    cur[2] = vertex_z;
    for (int k = 0; k < 3; k++) begin
      va[k] = (state_r == FR_CLOSE_MUL) ? first_r[k] : cur[k];
    end
  end

  // newell terms of the edge from the previous vertex to va
  for (genvar k = 0; k < 3; k++) begin : g_edge
    logic signed [DS_W-1:0]   diff;
    logic signed [DS_W-1:0]   sum;
    logic signed [PROD_W-1:0] prod;
    assign diff = DS_W'(prev_r[(k + 1) % 3]) - DS_W'(va[(k + 1) % 3]);
    assign sum = DS_W'(prev_r[(k + 2) % 3]) + DS_W'(va[(k + 2) % 3]);
    assign prod = diff * sum;
    assign edge_term[k] = ACC_W'(prod);
    assign q_data[k*ACC_W +: ACC_W] = acc_r[k] + prod_r[k];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_ACCEPT: begin
        if (accept && last_vertex) state_nxt = FR_CLOSE_MUL;
      end
      FR_CLOSE_MUL: state_nxt = FR_CLOSE_ADD;
      FR_CLOSE_ADD: begin
        if (!q_stat.full) state_nxt = FR_ACCEPT;
      end
      default: state_nxt = FR_ACCEPT;
    endcase
  end

  always_comb begin
    full = (state_r != FR_ACCEPT);
    q_push = (state_r == FR_CLOSE_ADD) && !q_stat.full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_ACCEPT;
      in_poly_r <= 1'b0;
      cnt_r <= '0;
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= '0;
        prod_r[k] <= '0;
        first_r[k] <= '0;
        prev_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        FR_ACCEPT: begin
          if (accept && !in_poly_r) begin
            in_poly_r <= 1'b1;
            cnt_r <= CNT_W'(1);
            for (int k = 0; k < 3; k++) begin
              first_r[k] <= cur[k];
              prev_r[k] <= cur[k];
              acc_r[k] <= '0;
              prod_r[k] <= '0;
            end
          end else begin
            for (int k = 0; k < 3; k++) acc_r[k] <= acc_r[k] + prod_r[k];
            if (accept && room) begin
              cnt_r <= cnt_r + CNT_W'(1);
              for (int k = 0; k < 3; k++) begin
                prod_r[k] <= edge_term[k];
                prev_r[k] <= cur[k];
              end
            end else begin
              for (int k = 0; k < 3; k++) prod_r[k] <= '0;
            end
          end
        end
        FR_CLOSE_MUL: begin
          // closing edge back to the first vertex
          for (int k = 0; k < 3; k++) begin
            acc_r[k] <= acc_r[k] + prod_r[k];
            prod_r[k] <= edge_term[k];
          end
        end
        FR_CLOSE_ADD: begin
          if (!q_stat.full) begin
            in_poly_r <= 1'b0;
            cnt_r <= '0;
            for (int k = 0; k < 3; k++) prod_r[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/pnn_queue.sv */
`default_nettype none

module pnn_queue import pnn_pkg::*; #(
  parameter int WIDTH = 3 * DEF_ACC_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output q_stat_t               stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign rdata = slot_r[rd_ptr_r];
  assign stat.full = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* sv/pnn_back.sv */
`default_nettype none

module pnn_back import pnn_pkg::*; #(
  parameter int ACC_W = DEF_ACC_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [3*ACC_W-1:0] q_data,
  input  wire q_stat_t            q_stat,
  output logic                    q_pop,
  input  wire logic [15:0]        threshold,
  input  wire logic               pop,
  output logic                    empty,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z,
  output logic [AREA_W-1:0]       squared_area,
  output logic                    degenerate
);

  localparam int SQ_W = 2 * ACC_W;
  localparam int NCH = (ACC_W + 15) / 16;
  localparam int PAD_W = NCH * 16;
  localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int RM_W = ACC_W + 3;
  localparam int IT_W = $clog2(ACC_W + 1);
  localparam int LIM_W = 32 + LIMIT_SHIFT;
  localparam int CMP_W = (SQ_W > LIM_W) ? SQ_W : LIM_W;
  localparam int SX_W = (SQ_W > AREA_SAT_BIT) ? SQ_W : AREA_SAT_BIT + 1;
  localparam int NUM_W = ACC_W + QUOT_W;
  localparam int QI_W = $clog2(QUOT_W + 1);
  localparam logic [1:0] LAST_COMP = 2'd2;

  back_state_t state_r, state_nxt;

  logic signed [ACC_W-1:0] c_r [3];
  logic [ACC_W-1:0]        m_r [3];
  logic [1:0]              comp_r;
  logic [CH_W-1:0]         chunk_r;
  logic [SQ_W-1:0]         t_r, s_r, rad_r;
  logic [31:0]             thr_sq_r;
  logic [RM_W-1:0]         rem_r;
  logic [ACC_W-1:0]        root_r;
  logic [IT_W-1:0]         iter_r;
  logic [ACC_W-1:0]        drem_r;
  logic [15:0]             dlow_r, quo_r;
  logic [QI_W-1:0]         dcnt_r;
  logic [15:0]             nrm_r [3];
  logic [AREA_W-1:0]       area_r;
  logic                    deg_r;
  logic                    out_valid_r;
  logic                    load_out;

  logic [ACC_W-1:0]        m_sel;
  logic [PAD_W-1:0]        m_pad;
  logic [15:0]             chunk;
  logic [ACC_W+15:0]       sq_prod;
  logic [SQ_W-1:0]         t_nxt;
  logic [CMP_W-1:0]        lim;
  logic                    deg_c;
  logic [SX_W-1:0]         s_x;
  logic [AREA_W-1:0]       area_c;
  logic [RM_W-1:0]         rem_t, trial;
  logic                    sq_ge;
  logic [NUM_W-1:0]        num;
  logic [ACC_W:0]          r2, lw;
  logic                    dge;
  logic [15:0]             q_fin, q_pos, q_neg, nrm_c;

  assign m_sel = m_r[comp_r];
  assign m_pad = PAD_W'(m_sel);
  assign chunk = m_pad[chunk_r*16 +: 16];
  assign sq_prod = (ACC_W + 16)'(m_sel) * (ACC_W + 16)'(chunk);
  assign t_nxt = SQ_W'({t_r, 16'b0}) + SQ_W'(sq_prod);

  assign lim = CMP_W'({thr_sq_r, {LIMIT_SHIFT{1'b0}}});
  assign deg_c = CMP_W'(s_r) <= lim;
  assign s_x = SX_W'(s_r);
  assign area_c = (|s_x[SX_W-1:AREA_SAT_BIT]) ? '1 : s_x[AREA_SAT_BIT-1:AREA_SHIFT];

  assign rem_t = RM_W'({rem_r, rad_r[SQ_W-1 -: 2]});
  assign trial = RM_W'({root_r, 2'b01});
  assign sq_ge = rem_t >= trial;

  assign num = NUM_W'({m_sel, 15'b0}) + NUM_W'(root_r >> 1);
  assign r2 = {drem_r, dlow_r[15]};
  assign lw = (ACC_W + 1)'(root_r);
  assign dge = r2 >= lw;
  assign q_fin = {quo_r[14:0], dge};
  assign q_pos = (q_fin > NORM_POS_MAX) ? NORM_POS_MAX : q_fin;
  assign q_neg = (q_fin > NORM_NEG_MAX) ? NORM_NEG_MAX : q_fin;
  assign nrm_c = c_r[comp_r][ACC_W-1] ? 16'(~q_neg + 16'd1) : q_pos;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:     if (!q_stat.empty) state_nxt = BK_SQUARE;
      BK_SQUARE:   if (chunk_r == '0 && comp_r == LAST_COMP) state_nxt = BK_CHECK;
      BK_CHECK:    state_nxt = deg_c ? BK_DONE : BK_SQRT;
      BK_SQRT:     if (iter_r == IT_W'(1)) state_nxt = BK_DIV_INIT;
      BK_DIV_INIT: state_nxt = BK_DIV_STEP;
      BK_DIV_STEP: begin
        if (dcnt_r == QI_W'(1)) state_nxt = (comp_r == LAST_COMP) ? BK_DONE : BK_DIV_INIT;
      end
      BK_DONE:     if (load_out) state_nxt = BK_IDLE;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == BK_IDLE) && !q_stat.empty;
    load_out = (state_r == BK_DONE) && (!out_valid_r || pop);
    empty = !out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          for (int k = 0; k < 3; k++) begin
            c_r[k] <= q_data[k*ACC_W +: ACC_W];
            m_r[k] <= q_data[k*ACC_W + ACC_W - 1] ? ACC_W'(-q_data[k*ACC_W +: ACC_W])
                                                  : q_data[k*ACC_W +: ACC_W];
          end
          s_r <= '0;
          t_r <= '0;
          comp_r <= '0;
          chunk_r <= CH_W'(NCH - 1);
          thr_sq_r <= threshold * threshold;
        end
      end
      BK_SQUARE: begin
        if (chunk_r == '0) begin
          s_r <= s_r + t_nxt;
          t_r <= '0;
          chunk_r <= CH_W'(NCH - 1);
          comp_r <= (comp_r == LAST_COMP) ? '0 : comp_r + 2'd1;
        end else begin
          t_r <= t_nxt;
          chunk_r <= chunk_r - CH_W'(1);
        end
      end
      BK_CHECK: begin
        area_r <= area_c;
        deg_r <= deg_c;
        // axis fallback, ties give the zero vector
        nrm_r[0] <= (c_r[0] > c_r[1] && c_r[0] > c_r[2]) ? NORM_POS_MAX : '0;
        nrm_r[1] <= (c_r[1] > c_r[0] && c_r[1] > c_r[2]) ? NORM_POS_MAX : '0;
        nrm_r[2] <= (c_r[2] > c_r[0] && c_r[2] > c_r[1]) ? NORM_POS_MAX : '0;
        rad_r <= s_r;
        rem_r <= '0;
        root_r <= '0;
        iter_r <= IT_W'(ACC_W);
        comp_r <= '0;
      end
      BK_SQRT: begin
        rem_r <= sq_ge ? rem_t - trial : rem_t;
        root_r <= {root_r[ACC_W-2:0], sq_ge};
        rad_r <= {rad_r[SQ_W-3:0], 2'b00};
        iter_r <= iter_r - IT_W'(1);
      end
      BK_DIV_INIT: begin
        drem_r <= num[NUM_W-1:QUOT_W];
        dlow_r <= num[QUOT_W-1:0];
        quo_r <= '0;
        dcnt_r <= QI_W'(QUOT_W);
      end
      BK_DIV_STEP: begin
        drem_r <= dge ? ACC_W'(r2 - lw) : r2[ACC_W-1:0];
        dlow_r <= {dlow_r[14:0], 1'b0};
        quo_r <= q_fin;
        dcnt_r <= dcnt_r - QI_W'(1);
        if (dcnt_r == QI_W'(1)) begin
          nrm_r[comp_r] <= nrm_c;
          comp_r <= (comp_r == LAST_COMP) ? '0 : comp_r + 2'd1;
        end
      end
      BK_DONE: begin
        if (load_out) begin
          normal_x <= nrm_r[0];
          normal_y <= nrm_r[1];
          normal_z <= nrm_r[2];
          squared_area <= area_r;
          degenerate <= deg_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/polygon_normal_newell.sv */
// channel  | ports                                   | transaction
// ---------+-----------------------------------------+---------------------------------
// vertex   | push, full, in_vertex_*, in_last_vertex | one vertex when push && !full
// result   | pop, empty, out_*                       | one polygon when pop && !empty
// config   | psel, penable, pwrite, paddr, pwdata    | threshold write on access phase
//
// the front sums newell terms at one vertex a cycle while full is low; after the last
// vertex it adds the closing edge, then hands the sums off to a two-entry queue
// the back squares, tests the threshold, then runs the bit-serial root and divider,
// and takes no new polygon from the queue until its result is loaded;
// a degenerate polygon skips both the root and the divider
// full stays high during the closing edge and the hand-off, which waits while the queue is full
// reset is synchronous: output empty, queue empty, threshold back to 1
`default_nettype none
`include "polygon_normal_newell_assert.svh"

module polygon_normal_newell import pnn_pkg::*; #(
  parameter int MAX_POLY_VERTS = DEF_MAX_POLY_VERTS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // vertex side
  input  wire logic                      push,
  output logic                           full,
  input  wire logic signed [COORD_W-1:0] in_vertex_x,
  input  wire logic signed [COORD_W-1:0] in_vertex_y,
  input  wire logic signed [COORD_W-1:0] in_vertex_z,
  input  wire logic                      in_last_vertex,
  // result side
  output logic                           empty,
  input  wire logic                      pop,
  output logic signed [15:0]             out_normal_x,
  output logic signed [15:0]             out_normal_y,
  output logic signed [15:0]             out_normal_z,
  output logic [AREA_W-1:0]              out_squared_area,
  output logic                           out_degenerate
);

  localparam int ACC_W = acc_width(MAX_POLY_VERTS);

  logic [15:0]          thr_r;
  logic                 cfg_wr;
  logic                 q_push;
  logic                 q_pop;
  logic [3*ACC_W-1:0]   q_wdata;
  logic [3*ACC_W-1:0]   q_rdata;
  q_stat_t              q_stat;
  logic [2:0]           nz_vec;

  // register file: only the length threshold lives here
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LENGTH_THRESHOLD);
  assign prdata = (paddr[2] == REG_LENGTH_THRESHOLD) ? {16'b0, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      thr_r <= pwdata[15:0];
    end
  end

  // front: edge products and accumulation
  pnn_front #(
    .MAX_POLY_VERTS (MAX_POLY_VERTS),
    .ACC_W          (ACC_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .vertex_x    (in_vertex_x),
    .vertex_y    (in_vertex_y),
    .vertex_z    (in_vertex_z),
    .last_vertex (in_last_vertex),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_stat      (q_stat)
  );

  // finished cross vectors wait here for the back
  pnn_queue #(
    .WIDTH (3 * ACC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: squares, threshold test, square root and the three divides
  pnn_back #(
    .ACC_W (ACC_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_data       (q_rdata),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .threshold    (thr_r),
    .pop          (pop),
    .empty        (empty),
    .normal_x     (out_normal_x),
    .normal_y     (out_normal_y),
    .normal_z     (out_normal_z),
    .squared_area (out_squared_area),
    .degenerate   (out_degenerate)
  );

  assign nz_vec = {out_normal_x != '0, out_normal_y != '0, out_normal_z != '0};

  // the queue never sees a push while it is full
  `PNN_ASSERT(a_no_push_full, clk, rst_n, q_push |-> !q_stat.full, "queue push while full")
  // a closing vertex always blocks the next transaction for the closing edge
  `PNN_ASSERT(a_close_blocks, clk, rst_n, (push && !full && in_last_vertex) |=> full, "no close stall")
  // axis fallback gives at most one non-zero component
  `PNN_ASSERT(a_deg_axis, clk, rst_n, (!empty && out_degenerate) |-> $onehot0(nz_vec), "bad axis")
  // nothing waits at the output right after reset
  `PNN_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> empty, "result after reset")

endmodule

`default_nettype wire
